@@ sv/olir_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ordered list core.
// Used by every module of the block; depends on nothing.
package olir_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	// Fixed field widths of the stream beats.
	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int CNT_O_W = 5;
	localparam int ST_W    = 2;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Bit positions of the result fields in the output tdata.
	localparam int OUT_RD_LSB  = 0;
	localparam int OUT_CNT_LSB = OUT_RD_LSB + VAL_W;
	localparam int OUT_ST_LSB  = OUT_CNT_LSB + CNT_O_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND     = 3'd0,
		CMD_PREPEND    = 3'd1,
		CMD_INSERT_AT  = 3'd2,
		CMD_DROP_LAST  = 3'd3,
		CMD_DROP_FIRST = 3'd4,
		CMD_REMOVE_AT  = 3'd5,
		CMD_READ_AT    = 3'd6,
		CMD_CLEAR      = 3'd7
	} cmd_e;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		SH_HOLD   = 2'd0,
		SH_INSERT = 2'd1,
		SH_REMOVE = 2'd2
	} shift_e;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic   fire;
		shift_e kind;
	} cell_cmd_t;

endpackage

@@ sv/olir_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the ordered list chain.
// Depends on olir_pkg for the broadcast command type.
module olir_cell
	import olir_pkg::*;
#(
	parameter int DATA_W = DATA_W_DEF,
	parameter int IDX_W  = 4,
	parameter int INDEX  = 0
) (
	input  logic              clk,
	input  cell_cmd_t         ccmd,
	input  logic [IDX_W-1:0]  at,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	// Each cell compares its own place with the broadcast index and picks
	// its next entry: keep, take the new value, or take a neighbor's entry.
	always_ff @(posedge clk) begin
		if (ccmd.fire) begin
			unique case (ccmd.kind)
				SH_INSERT: begin
					if (MY_IDX == at) begin
						data_q <= value;
					end else if (MY_IDX > at) begin
						data_q <= left_data;
					end
				end
				SH_REMOVE: begin
					if (MY_IDX >= at) begin
						data_q <= right_data;
					end
				end
				default: begin
					data_q <= data_q;
				end
			endcase
		end
	end

endmodule

@@ sv/olir_ctrl.sv @@
`timescale 1ns / 1ps
// Command decoder and entry counter of the ordered list core.
// Depends on olir_pkg for command, status and cell command types.
module olir_ctrl
	import olir_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [CMD_W-1:0] command,
	input  logic [POS_W-1:0] position,
	output cell_cmd_t        ccmd,
	output logic [IDX_W-1:0] at,
	output logic [CNT_W-1:0] count_d,
	output status_e          status,
	output logic             rd_ok
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             full;
	logic             empty;
	shift_e           kind;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		kind    = SH_HOLD;
		at      = '0;
		count_d = count_q;
		status  = ST_OK;
		rd_ok   = 1'b0;
		unique case (cmd_e'(command))
			CMD_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					kind    = SH_INSERT;
					at      = count_q[IDX_W-1:0];
					count_d = count_q + 1'b1;
				end
			end
			CMD_PREPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					kind    = SH_INSERT;
					count_d = count_q + 1'b1;
				end
			end
			CMD_INSERT_AT: begin
				if (full) begin
					status = ST_FULL;
				end else if (pos_x > cnt_x) begin
					status = ST_BAD_POS;
				end else begin
					kind    = SH_INSERT;
					at      = pos_x[IDX_W-1:0];
					count_d = count_q + 1'b1;
				end
			end
			CMD_DROP_LAST: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			CMD_DROP_FIRST: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					kind    = SH_REMOVE;
					count_d = count_q - 1'b1;
				end
			end
			CMD_REMOVE_AT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status = ST_BAD_POS;
				end else begin
					kind    = SH_REMOVE;
					at      = pos_x[IDX_W-1:0];
					count_d = count_q - 1'b1;
				end
			end
			CMD_READ_AT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status = ST_BAD_POS;
				end else begin
					at    = pos_x[IDX_W-1:0];
					rd_ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign ccmd.fire = fire && (kind != SH_HOLD);
	assign ccmd.kind = kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_d;
		end
	end

endmodule

@@ sv/ordered_list_insert_remove_core.sv @@
`timescale 1ns / 1ps
// Ordered list core: a bounded list that keeps its order under insertion
// and removal at any position. Depends on olir_pkg, olir_ctrl, olir_cell.
//
// Usage: one command beat enters on the s_axis channel and yields exactly
// one result beat on the m_axis channel. The command beat carries the
// command code, a position and a value; the result beat carries the entry
// read (zero unless a read succeeded), the entry count after the command
// and a status code.
// The result is registered at the edge that accepts the command.
// Throughput is one command per cycle while the receiver takes each result,
// set by the cell chain, in which every cell loads its next entry from
// the value or a neighbor at the edge that accepts the command.
// When the receiver stalls, the result register holds its beat and
// s_axis_tready stays low until that beat is taken; a beat taken in the
// same cycle frees the register for the next command.
// Reset clears the entry count and the result valid flag, not the result
// data; the cells are not cleared, as only entries below the count are ever read.
module ordered_list_insert_remove_core
	import olir_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int DATA_W = DATA_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] command, [7:3] position, [39:8] value
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [31:0] read_value, [36:32] entry_count, [38:37] status, [39] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EXT_W = (DATA_W > VAL_W) ? DATA_W : VAL_W;
	localparam int CEX_W = (CNT_W > CNT_O_W) ? CNT_W : CNT_O_W;

	logic              fire;
	logic [CMD_W-1:0]  command;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value;
	cell_cmd_t         ccmd;
	logic [IDX_W-1:0]  at;
	logic [CNT_W-1:0]  count_d;
	status_e           status;
	logic              rd_ok;
	logic [EXT_W-1:0]  val_ext;
	logic [DATA_W-1:0] cell_val;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] left_data [DEPTH];
	logic [DATA_W-1:0] right_data [DEPTH];
	logic [EXT_W-1:0]  rd_ext;
	logic [CEX_W-1:0]  cnt_ext;
	logic [VAL_W-1:0]  read_value;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	assign command  = s_axis_tdata[CMD_W-1:0];
	assign position = s_axis_tdata[CMD_W +: POS_W];
	assign value    = s_axis_tdata[CMD_W+POS_W +: VAL_W];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign fire          = s_axis_tvalid && s_axis_tready;

	olir_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.command  (command),
		.position (position),
		.ccmd     (ccmd),
		.at       (at),
		.count_d  (count_d),
		.status   (status),
		.rd_ok    (rd_ok)
	);

	assign val_ext  = EXT_W'(value);
	assign cell_val = val_ext[DATA_W-1:0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_data[i] = '0;
		end else begin : g_inner_l
			assign left_data[i] = cell_data[i-1];
		end
		// The top cell keeps its own entry on removal; it lies past the count.
		if (i == DEPTH - 1) begin : g_last
			assign right_data[i] = cell_data[i];
		end else begin : g_inner_r
			assign right_data[i] = cell_data[i+1];
		end

		olir_cell #(
			.DATA_W (DATA_W),
			.IDX_W  (IDX_W),
			.INDEX  (i)
		) u_cell (
			.clk        (clk),
			.ccmd       (ccmd),
			.at         (at),
			.value      (cell_val),
			.left_data  (left_data[i]),
			.right_data (right_data[i]),
			.data_q     (cell_data[i])
		);
	end

	assign rd_ext     = EXT_W'(cell_data[at]);
	assign read_value = rd_ok ? rd_ext[VAL_W-1:0] : '0;
	assign cnt_ext    = CEX_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {1'b0, status, cnt_ext[CNT_O_W-1:0], read_value};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ sv/olir_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the ordered list core, bound to the top level.
// Depends on olir_pkg for field positions and status codes.
module olir_chk
	import olir_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [VAL_W-1:0]   rd_f;
	logic [CNT_O_W-1:0] cnt_f;
	logic [ST_W-1:0]    st_f;

	assign rd_f  = m_axis_tdata[OUT_RD_LSB +: VAL_W];
	assign cnt_f = m_axis_tdata[OUT_CNT_LSB +: CNT_O_W];
	assign st_f  = m_axis_tdata[OUT_ST_LSB +: ST_W];

	// A stalled result beat holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Every accepted command beat produces a result beat in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted command produced no result beat");

	// The input side stalls only while a result beat is waiting.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");

	// A nonzero read value only comes with a successful command.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (rd_f != '0) |-> st_f == ST_OK)
		else $error("read value returned with an error status");

	// The reported count never exceeds the list depth.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> int'(cnt_f) <= DEPTH)
		else $error("entry count beyond list depth");

endmodule

bind ordered_list_insert_remove_core olir_chk #(.DEPTH(DEPTH)) u_olir_chk (.*);

@@ sim/ordered_list_insert_remove_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_insert_remove_core: random command
// streams with idling and back-pressure on both sides, checked against a list tracker.
// Depends on olir_pkg and the core module.
module ordered_list_insert_remove_core_tb;
	import olir_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;

	// Command mixes for the random phases.
	localparam int LEAN_GROW   = 0;
	localparam int LEAN_SHRINK = 1;
	localparam int LEAN_EVEN   = 2;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		logic [CNT_O_W-1:0] entry_count;
		status_e            status;
	} list_reply_t;

	// Tracks the list contents and queues the reply each command should produce.
	class ordered_list_tracker;
		logic [VAL_W-1:0] cells[LIST_DEPTH];
		int               used;
		list_reply_t      expected_replies[$];
		int               errors;
		int               checked;
		int               outcome_tally[4];

		function new();
			used = 0;
			errors = 0;
			checked = 0;
			foreach (outcome_tally[i]) outcome_tally[i] = 0;
		endfunction

		function void open_gap(int at, logic [VAL_W-1:0] val);
			for (int i = used; i > at; i--) cells[i] = cells[i-1];
			cells[at] = val;
			used++;
		endfunction

		function void close_gap(int at);
			for (int i = at; i + 1 < used; i++) cells[i] = cells[i+1];
			used--;
		endfunction

		function void apply_command(cmd_e cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
			list_reply_t r;
			r.read_value = '0;
			r.status = ST_OK;
			case (cmd)
				CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT: begin
					// A full list is reported before the position is looked at.
					if (used >= LIST_DEPTH) r.status = ST_FULL;
					else if (cmd == CMD_APPEND) open_gap(used, val);
					else if (cmd == CMD_PREPEND) open_gap(0, val);
					else if (int'(pos) > used) r.status = ST_BAD_POS;
					else open_gap(int'(pos), val);
				end
				CMD_DROP_LAST, CMD_DROP_FIRST: begin
					if (used == 0) r.status = ST_EMPTY;
					else if (cmd == CMD_DROP_LAST) used--;
					else close_gap(0);
				end
				CMD_REMOVE_AT, CMD_READ_AT: begin
					if (used == 0) r.status = ST_EMPTY;
					else if (int'(pos) >= used) r.status = ST_BAD_POS;
					else if (cmd == CMD_REMOVE_AT) close_gap(int'(pos));
					else r.read_value = cells[pos];
				end
				CMD_CLEAR: used = 0;
				default: used = 0;
			endcase
			r.entry_count = CNT_O_W'(used);
			outcome_tally[r.status]++;
			expected_replies = {expected_replies, r};
		endfunction

		function void check_reply(logic [OUT_TDATA_W-1:0] beat);
			list_reply_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: result beat %h arrived with no command waiting", $time, beat);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			checked++;
			if (beat[OUT_RD_LSB +: VAL_W] !== want.read_value) begin
				$display("%0t: read_value mismatch, expected %h, got %h",
					$time, want.read_value, beat[OUT_RD_LSB +: VAL_W]);
				errors++;
			end
			if (beat[OUT_CNT_LSB +: CNT_O_W] !== want.entry_count) begin
				$display("%0t: entry_count mismatch, expected %0d, got %0d",
					$time, want.entry_count, beat[OUT_CNT_LSB +: CNT_O_W]);
				errors++;
			end
			if (beat[OUT_ST_LSB +: ST_W] !== want.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d",
					$time, want.status, beat[OUT_ST_LSB +: ST_W]);
				errors++;
			end
			if (beat[OUT_TDATA_W-1] !== 1'b0) begin
				$display("%0t: pad bit mismatch, expected 0, got %b", $time, beat[OUT_TDATA_W-1]);
				errors++;
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_request;
	int stall_cycles;

	ordered_list_tracker tracker;

	ordered_list_insert_remove_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one command beat and returns at the edge that accepts it.
	task automatic send_command(input cmd_e cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, pos, cmd};
		do @(posedge clk); while (!s_axis_tready);
		tracker.apply_command(cmd, pos, val);
	endtask

	// Withdraws the last beat so that it is not taken a second time.
	task automatic go_quiet();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		go_quiet();
		while (tracker.pending() > 0) @(posedge clk);
	endtask

	function automatic cmd_e pick_command(int lean);
		int r;
		int cut[7];
		r = $urandom_range(0, 99);
		case (lean)
			LEAN_GROW:   cut = '{25, 45, 70, 74, 78, 84, 99};
			LEAN_SHRINK: cut = '{8, 14, 24, 44, 62, 82, 98};
			default:     cut = '{14, 26, 40, 50, 60, 72, 96};
		endcase
		for (int k = 0; k < 7; k++)
			if (r < cut[k]) return cmd_e'(CMD_W'(k));
		return CMD_CLEAR;
	endfunction

	task automatic run_random(int n, int lean);
		cmd_e             cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		int               pick;
		for (int i = 0; i < n; i++) begin
			cmd = pick_command(lean);
			// Mostly positions near the live range, sometimes anything the field holds.
			if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 31));
			else pos = POS_W'($urandom_range(0, tracker.used));
			pick = $urandom_range(0, 9);
			if (pick == 0) val = '0;
			else if (pick == 1) val = '1;
			else val = $urandom;
			send_command(cmd, pos, val);
		end
	endtask

	// Result side: random ready gaps, plus one long hold-off when asked.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = rx_idle_on ? $urandom_range(0, 7) : 0;
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_reply(m_axis_tdata);
		end
	end

	// Ends the run if neither side moves a beat for too long.
	initial begin
		stall_cycles = 0;
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		tracker       = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		tx_idle_on    = 1'b0;
		rx_idle_on    = 1'b0;
		hold_request  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: the drop, remove, read and insert commands on an empty list, edges of the position range, extremes.
		send_command(CMD_DROP_LAST, 0, 0);
		send_command(CMD_DROP_FIRST, 0, 0);
		send_command(CMD_REMOVE_AT, 0, 0);
		send_command(CMD_READ_AT, 31, 0);
		send_command(CMD_INSERT_AT, 1, 32'h1111_1111);
		send_command(CMD_INSERT_AT, 0, 32'hFFFF_FFFF);
		send_command(CMD_APPEND, 0, 32'h0000_0000);
		send_command(CMD_PREPEND, 0, 32'hA5A5_A5A5);
		send_command(CMD_INSERT_AT, 3, 32'h5A5A_5A5A);
		send_command(CMD_INSERT_AT, 5, 32'h2222_2222);
		for (int i = 0; i < 5; i++) send_command(CMD_READ_AT, POS_W'(i), 0);
		send_command(CMD_REMOVE_AT, 3, 0);
		send_command(CMD_REMOVE_AT, 3, 0);
		send_command(CMD_REMOVE_AT, 0, 0);
		send_command(CMD_DROP_FIRST, 0, 0);
		send_command(CMD_DROP_LAST, 0, 0);
		send_command(CMD_APPEND, 0, 32'h1234_5678);
		send_command(CMD_READ_AT, 16, 0);
		send_command(CMD_CLEAR, 0, 0);
		send_command(CMD_READ_AT, 0, 0);

		// Back-to-back stretch with no idling on either side.
		run_random(150, LEAN_GROW);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		run_random(200, LEAN_EVEN);
		wait_drained();

		tx_idle_on = 1'b0;
		run_random(150, LEAN_SHRINK);

		// The receiver holds off while commands keep coming, so the input stalls.
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		hold_request = 1'b1;
		run_random(150, LEAN_GROW);
		rx_idle_on = 1'b1;
		hold_request = 1'b1;
		run_random(200, LEAN_EVEN);
		wait_drained();

		run_random(150, LEAN_SHRINK);
		run_random(200, LEAN_EVEN);

		wait_drained();
		repeat (4) @(posedge clk);

		$display("Checked %0d result beats from directed and random command streams.",
			tracker.checked);
		$display("Outcomes seen: ok %0d, bad position %0d, full %0d, empty %0d.",
			tracker.outcome_tally[ST_OK], tracker.outcome_tally[ST_BAD_POS],
			tracker.outcome_tally[ST_FULL], tracker.outcome_tally[ST_EMPTY]);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ ordered_list_insert_remove_core.f @@
sv/olir_pkg.sv
sv/olir_cell.sv
sv/olir_ctrl.sv
sv/ordered_list_insert_remove_core.sv
sv/olir_chk.sv
sim/ordered_list_insert_remove_core_tb.sv
